/* sv/pfc_pkg.sv */
package pfc_pkg;

    // Geometry of the key square and the letter code.
    localparam int SIDE      = 5;
    localparam int LETTER_W  = 5;
    localparam int IDX_W     = 3;
    localparam int ROW_W     = SIDE * LETTER_W;

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = ROW_W;

    // Queue between the pairing front and the cipher back.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = 2;
    localparam int QUEUE_CNT_W = 3;

    // Letter codes that the cipher treats specially.
    localparam logic [LETTER_W-1:0] LETTER_I   = 5'd8;
    localparam logic [LETTER_W-1:0] LETTER_J   = 5'd9;
    localparam logic [LETTER_W-1:0] LETTER_X   = 5'd23;
    localparam logic [LETTER_W-1:0] LETTER_Z   = 5'd25;
    localparam logic [LETTER_W-1:0] LETTER_MAX = 5'd25;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ROW0     = 3'd0,
        REG_ROW1     = 3'd1,
        REG_ROW2     = 3'd2,
        REG_ROW3     = 3'd3,
        REG_ROW4     = 3'd4,
        REG_DECIPHER = 3'd5,
        REG_MERGE    = 3'd6
    } t_cfg_reg;

    // Letter merge rules; the unused code passes letters through.
    typedef enum logic [1:0] {
        MERGE_J_TO_I = 2'd0,
        MERGE_I_TO_J = 2'd1,
        MERGE_Z_TO_J = 2'd2
    } t_merge;

    // Key square: row, then column, then letter bits.
    typedef logic [SIDE-1:0][SIDE-1:0][LETTER_W-1:0] t_square;

    // One digram waiting to be enciphered.
    typedef struct packed {
        logic [LETTER_W-1:0] first;
        logic [LETTER_W-1:0] second;
        logic                fin;
    } t_digram;

    // A push from the front into the queue.
    typedef struct packed {
        logic    valid;
        t_digram dig;
    } t_push;

    // Queue head as seen by the back.
    typedef struct packed {
        logic    valid;
        t_digram dig;
    } t_head;

    // Position of a letter in the key square.
    typedef struct packed {
        logic             found;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
    } t_loc;

endpackage

/* sv/playfair_digram_cipher_core.sv */
// Playfair digram cipher core.
//
// Input channel (i_valid, o_stall, i_letter, i_end_of_text) takes one letter
// code per transfer, 0 for a through 25 for z; i_end_of_text marks the last
// letter of a message. Output channel (o_valid, i_stall and the o_out_*,
// o_final_pair, o_not_in_square fields) delivers one enciphered or
// deciphered digram per transfer.
// Letters are taken one per cycle while o_stall is low. A letter that
// repeats the held letter at the end of a message makes two digrams, and the
// input stalls while the second one is queued. A completed digram is queued;
// from the queue head it passes a stage that locates its letters in the key
// square, then the row, column or rectangle rule into the output register.
// Digrams leave at one per cycle while i_stall is low.
// A four-entry queue sits between the pairing logic and the cipher pipeline.
// While i_stall is high the output holds its digram; the queue absorbs input
// until it fills, then o_stall rises.
// Reset clears the held letter, the queue, the pipeline and all
// configuration registers. The user writes the configuration port (i_cfg_we,
// i_cfg_index, i_cfg_data) only while no message is in flight; not enforced.
module playfair_digram_cipher_core
    import pfc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [LETTER_W-1:0]   i_letter,
    input  logic                  i_end_of_text,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [LETTER_W-1:0]   o_out_first,
    output logic [LETTER_W-1:0]   o_out_second,
    output logic                  o_final_pair,
    output logic                  o_not_in_square,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_square    r_square;
    logic       r_decipher;
    logic [1:0] r_merge;

    t_push push;
    logic  queue_full;
    t_head head;
    logic  pop;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_square   <= '0;
            r_decipher <= 1'b0;
            r_merge    <= 2'd0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_index))
                REG_ROW0:     r_square[0] <= i_cfg_data[ROW_W-1:0];
                REG_ROW1:     r_square[1] <= i_cfg_data[ROW_W-1:0];
                REG_ROW2:     r_square[2] <= i_cfg_data[ROW_W-1:0];
                REG_ROW3:     r_square[3] <= i_cfg_data[ROW_W-1:0];
                REG_ROW4:     r_square[4] <= i_cfg_data[ROW_W-1:0];
                REG_DECIPHER: r_decipher  <= i_cfg_data[0];
                REG_MERGE:    r_merge     <= i_cfg_data[1:0];
                default:      r_merge     <= r_merge;
            endcase
        end
    end

    // Pairing front end.
    pfc_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_letter      (i_letter),
        .i_end_of_text (i_end_of_text),
        .i_merge_rule  (r_merge),
        .i_queue_full  (queue_full),
        .o_push        (push)
    );

    // Digram queue.
    pfc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_full  (queue_full),
        .o_head  (head),
        .i_pop   (pop)
    );

    // Cipher back end.
    pfc_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_square        (r_square),
        .i_decipher      (r_decipher),
        .i_head          (head),
        .o_pop           (pop),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_out_first     (o_out_first),
        .o_out_second    (o_out_second),
        .o_final_pair    (o_final_pair),
        .o_not_in_square (o_not_in_square)
    );

endmodule

/* sv/pfc_front.sv */
module pfc_front
    import pfc_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [LETTER_W-1:0] i_letter,
    input  logic                i_end_of_text,
    input  logic [1:0]          i_merge_rule,
    input  logic                i_queue_full,
    output t_push               o_push
);

    logic                r_held_valid;
    logic [LETTER_W-1:0] r_held_letter;
    logic                r_pend_valid;
    logic [LETTER_W-1:0] r_pend_letter;

    logic                n_held_valid;
    logic [LETTER_W-1:0] n_held_letter;
    logic                n_pend_valid;
    logic [LETTER_W-1:0] n_pend_letter;

    logic                accept;
    logic [LETTER_W-1:0] merged;

    // A pending second digram or a full queue holds off the sender.
    assign o_stall = r_pend_valid | i_queue_full;
    assign accept  = i_valid & ~o_stall;

    // Letter merge ahead of pairing.
    always_comb begin
        merged = i_letter;
        case (t_merge'(i_merge_rule))
            MERGE_J_TO_I: if (i_letter == LETTER_J) merged = LETTER_I;
            MERGE_I_TO_J: if (i_letter == LETTER_I) merged = LETTER_J;
            MERGE_Z_TO_J: if (i_letter == LETTER_Z) merged = LETTER_J;
            default:      merged = i_letter;
        endcase
    end

    // Pairing: decide which digram, if any, each transfer produces.
    always_comb begin
        n_held_valid  = r_held_valid;
        n_held_letter = r_held_letter;
        n_pend_valid  = r_pend_valid;
        n_pend_letter = r_pend_letter;
        o_push        = '0;

        if (r_pend_valid && !i_queue_full) begin
            // Second digram of a repeat on the final letter.
            o_push.valid      = 1'b1;
            o_push.dig.first  = r_pend_letter;
            o_push.dig.second = LETTER_X;
            o_push.dig.fin    = 1'b1;
            n_pend_valid      = 1'b0;
        end else if (accept) begin
            if (!r_held_valid) begin
                if (i_end_of_text) begin
                    o_push.valid      = 1'b1;
                    o_push.dig.first  = merged;
                    o_push.dig.second = LETTER_X;
                    o_push.dig.fin    = 1'b1;
                end else begin
                    n_held_valid  = 1'b1;
                    n_held_letter = merged;
                end
            end else if (r_held_letter == merged) begin
                // Repeated letter: close the held one with x.
                o_push.valid      = 1'b1;
                o_push.dig.first  = r_held_letter;
                o_push.dig.second = LETTER_X;
                o_push.dig.fin    = 1'b0;
                if (i_end_of_text) begin
                    n_held_valid  = 1'b0;
                    n_pend_valid  = 1'b1;
                    n_pend_letter = merged;
                end
            end else begin
                o_push.valid      = 1'b1;
                o_push.dig.first  = r_held_letter;
                o_push.dig.second = merged;
                o_push.dig.fin    = i_end_of_text;
                n_held_valid      = 1'b0;
            end
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_valid <= 1'b0;
            r_pend_valid <= 1'b0;
        end else begin
            r_held_valid <= n_held_valid;
            r_pend_valid <= n_pend_valid;
        end
    end

    // Held and pending letters.
    always_ff @(posedge i_clk) begin
        r_held_letter <= n_held_letter;
        r_pend_letter <= n_pend_letter;
    end

endmodule

/* sv/pfc_queue.sv */
module pfc_queue
    import pfc_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_push i_push,
    output logic  o_full,
    output t_head o_head,
    input  logic  i_pop
);

    t_digram                r_mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] r_wr_ptr;
    logic [QUEUE_PTR_W-1:0] r_rd_ptr;
    logic [QUEUE_CNT_W-1:0] r_count;

    logic do_push;
    logic do_pop;

    assign o_full       = (r_count == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign o_head.valid = (r_count != '0);
    assign o_head.dig   = r_mem[r_rd_ptr];

    assign do_push = i_push.valid & ~o_full;
    assign do_pop  = i_pop & o_head.valid;

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) r_wr_ptr <= r_wr_ptr + 1'b1;
            if (do_pop)  r_rd_ptr <= r_rd_ptr + 1'b1;
            r_count <= r_count + QUEUE_CNT_W'(do_push) - QUEUE_CNT_W'(do_pop);
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wr_ptr] <= i_push.dig;
    end

endmodule

/* sv/pfc_back.sv */
module pfc_back
    import pfc_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_square             i_square,
    input  logic                i_decipher,
    input  t_head               i_head,
    output logic                o_pop,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [LETTER_W-1:0] o_out_first,
    output logic [LETTER_W-1:0] o_out_second,
    output logic                o_final_pair,
    output logic                o_not_in_square
);

    // First match in row-major order wins.
    function automatic t_loc locate(input logic [LETTER_W-1:0] letter,
                                    input t_square sq);
        t_loc loc;
        loc = '0;
        for (int r = SIDE - 1; r >= 0; r--) begin
            for (int c = SIDE - 1; c >= 0; c--) begin
                if (sq[r][c] == letter) begin
                    loc.found = 1'b1;
                    loc.row   = IDX_W'(r);
                    loc.col   = IDX_W'(c);
                end
            end
        end
        if (letter > LETTER_MAX) loc.found = 1'b0;
        return loc;
    endfunction

    // One step around the square, forward or back.
    function automatic logic [IDX_W-1:0] wrap_step(input logic [IDX_W-1:0] idx,
                                                   input logic back);
        logic [IDX_W-1:0] res;
        if (back) res = (idx == '0) ? IDX_W'(SIDE - 1) : idx - 1'b1;
        else      res = (idx == IDX_W'(SIDE - 1)) ? '0 : idx + 1'b1;
        return res;
    endfunction

    logic    r_s1_valid;
    t_digram r_s1_dig;
    t_loc    r_s1_loc_a;
    t_loc    r_s1_loc_b;

    logic                r_out_valid;
    logic [LETTER_W-1:0] r_out_first;
    logic [LETTER_W-1:0] r_out_second;
    logic                r_out_fin;
    logic                r_out_bad;

    logic                out_en;
    logic                s1_en;
    logic [LETTER_W-1:0] n_first;
    logic [LETTER_W-1:0] n_second;
    logic                n_bad;

    // The whole back pipeline moves whenever the output register can take data.
    assign out_en = ~r_out_valid | ~i_stall;
    assign s1_en  = ~r_s1_valid | out_en;
    assign o_pop  = i_head.valid & s1_en;

    // Stage 1: find both letters in the square.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_en) begin
            r_s1_valid <= i_head.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_en) begin
            r_s1_dig   <= i_head.dig;
            r_s1_loc_a <= locate(i_head.dig.first, i_square);
            r_s1_loc_b <= locate(i_head.dig.second, i_square);
        end
    end

    // Stage 2: row, column or rectangle rule.
    always_comb begin
        n_bad    = ~r_s1_loc_a.found | ~r_s1_loc_b.found;
        n_first  = r_s1_dig.first;
        n_second = r_s1_dig.second;
        if (!n_bad) begin
            if (r_s1_loc_a.row == r_s1_loc_b.row) begin
                n_first  = i_square[r_s1_loc_a.row][wrap_step(r_s1_loc_a.col, i_decipher)];
                n_second = i_square[r_s1_loc_b.row][wrap_step(r_s1_loc_b.col, i_decipher)];
            end else if (r_s1_loc_a.col == r_s1_loc_b.col) begin
                n_first  = i_square[wrap_step(r_s1_loc_a.row, i_decipher)][r_s1_loc_a.col];
                n_second = i_square[wrap_step(r_s1_loc_b.row, i_decipher)][r_s1_loc_b.col];
            end else begin
                n_first  = i_square[r_s1_loc_a.row][r_s1_loc_b.col];
                n_second = i_square[r_s1_loc_b.row][r_s1_loc_a.col];
            end
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_en) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_en) begin
            r_out_first  <= n_first;
            r_out_second <= n_second;
            r_out_fin    <= r_s1_dig.fin;
            r_out_bad    <= n_bad;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_out_first     = r_out_first;
    assign o_out_second    = r_out_second;
    assign o_final_pair    = r_out_fin;
    assign o_not_in_square = r_out_bad;

endmodule

/* sv/pfc_checker.sv */
module pfc_checker
    import pfc_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_stall,
    input logic                o_valid,
    input logic                i_stall,
    input logic [LETTER_W-1:0] o_out_first,
    input logic [LETTER_W-1:0] o_out_second,
    input logic                o_final_pair,
    input logic                o_not_in_square
);

    // A stalled result stays offered.
    a_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("result dropped while stalled");

    // A stalled result keeps its fields.
    a_payload_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> $stable(o_out_first) && $stable(o_out_second)
            && $stable(o_final_pair) && $stable(o_not_in_square))
        else $error("result changed while stalled");

    // Reset empties the cipher pipeline.
    a_reset_no_result: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result offered right after reset");

    // Reset clears the queue and any pending digram, so input is open.
    a_reset_open: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_stall)
        else $error("input stalled right after reset");

endmodule

bind playfair_digram_cipher_core pfc_checker u_checker (.*);
